[src/alse_pkg.sv]
// Shared types and codes for the array list shift engine.
`default_nettype none

package alse_pkg;

    // Command codes carried in the func field.
    localparam logic [2:0] FN_APPEND       = 3'd0;
    localparam logic [2:0] FN_PREPEND      = 3'd1;
    localparam logic [2:0] FN_REMOVE_BACK  = 3'd2;
    localparam logic [2:0] FN_REMOVE_FRONT = 3'd3;
    localparam logic [2:0] FN_DELETE_AT    = 3'd4;
    localparam logic [2:0] FN_DELETE_VAL   = 3'd5;
    localparam logic [2:0] FN_READ_AT      = 3'd6;
    localparam logic [2:0] FN_READ_BACK    = 3'd7;

    // Status codes returned with every result.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_ZERO     = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;

    // Stream payload widths.
    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned OUT_TDATA_W = 48;

    // What every cell does with its word at the commit edge.
    typedef enum logic [1:0] {
        CM_HOLD,
        CM_APPEND,
        CM_PREPEND,
        CM_REMOVE
    } t_cell_mode;

    // Control broadcast from the sequencer to the row of cells.
    typedef struct packed {
        t_cell_mode mode;
        logic       by_value;
    } t_cell_ctl;

endpackage

`default_nettype wire

[src/array_list_shift_engine_unit.sv]
// Top level of the array list shift engine: command sequencer over a row of list cells.
// A push or a command rejected up front goes from the input transfer straight to commit;
// commands that locate an entry (pops, deletes, reads) pass the match, select and commit
// steps. A new command is taken only in the idle state, once the last one has committed;
// a result not yet taken holds the commit step until the output register frees.
// Reset (i_rst_n low, synchronous) empties the list and clears the output valid.
`default_nettype none

module array_list_shift_engine_unit #(
    parameter int unsigned DEPTH     = 256,
    parameter int unsigned WORD_BITS = 32
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    // func [2:0], value [34:3], position [42:35], zero fill [47:43]
    input  wire  [alse_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    // data [31:0], status [34:32], count [43:35], zero fill [47:44]
    output logic [alse_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import alse_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned IW = $clog2(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_SELECT,
        S_COMMIT
    } t_state;

    // Input field unpacking.
    logic [2:0]           w_func;
    logic [31:0]          w_value;
    logic [7:0]           w_position;
    logic [63:0]          w_val64;
    logic [WORD_BITS-1:0] w_val;
    logic [31:0]          w_pos32;
    logic [31:0]          w_fill32;
    logic [CW-1:0]        w_fill_m1;

    assign w_func     = i_s_tdata[2:0];
    assign w_value    = i_s_tdata[34:3];
    assign w_position = i_s_tdata[42:35];
    assign w_val64    = {32'd0, w_value};
    assign w_val      = w_val64[WORD_BITS-1:0];
    assign w_pos32    = {24'd0, w_position};

    // Sequencer registers.
    t_state               r_state;
    logic [CW-1:0]        r_fill;
    logic [WORD_BITS-1:0] r_val;
    logic [IW-1:0]        r_target;
    logic                 r_by_value;
    logic                 r_need_match;
    t_cell_mode           r_mode;
    logic                 r_inc;
    logic                 r_dec;
    logic [2:0]           r_status;
    logic [DEPTH-1:0]     r_sel;
    logic [DEPTH-1:0]     r_mask;
    logic                 r_any;
    logic                 r_out_valid;
    logic [31:0]          r_out_data;
    logic [2:0]           r_out_status;
    logic [8:0]           r_out_count;

    assign w_fill32  = 32'(r_fill);
    assign w_fill_m1 = r_fill - CW'(1);

    // Row of cells.
    logic [WORD_BITS-1:0] w_word [DEPTH];
    logic [DEPTH-1:0]     w_match;
    t_cell_ctl            w_ctl;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_BITS-1:0] w_left;
        logic [WORD_BITS-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = r_val;
        end else begin : g_mid_l
            assign w_left = w_word[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_word[g+1];
        end
        alse_cell #(
            .WORD_BITS (WORD_BITS),
            .CW        (CW),
            .IW        (IW),
            .CELL_IDX  (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_target (r_target),
            .i_fill   (r_fill),
            .i_value  (r_val),
            .i_left   (w_left),
            .i_right  (w_right),
            .i_rm     (r_mask[g]),
            .o_word   (w_word[g]),
            .o_match  (w_match[g])
        );
    end

    // First hit and the run of cells from it to the end of the row.
    logic [DEPTH-1:0] w_first;
    logic [DEPTH-1:0] w_from_first;
    assign w_first      = w_match & (~w_match + DEPTH'(1));
    assign w_from_first = ~(w_first - DEPTH'(1));

    // Selected entry: the one-hot select gates an OR across the row.
    logic [WORD_BITS-1:0] w_sel_data;
    always_comb begin
        w_sel_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_sel_data = w_sel_data | (r_sel[i] ? w_word[i] : '0);
        end
    end

    // Commit decision for the command in flight.
    logic                 w_out_free;
    logic                 w_commit;
    logic                 w_ok;
    logic [CW-1:0]        w_next_fill;
    logic [63:0]          w_data64;
    logic [31:0]          w_count32;

    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_commit    = (r_state == S_COMMIT) && w_out_free;
    assign w_ok        = !r_need_match || r_any;
    assign w_next_fill = r_fill + CW'(w_ok && r_inc) - CW'(w_ok && r_dec);
    assign w_data64    = (w_ok && r_need_match) ? 64'(w_sel_data) : 64'd0;
    assign w_count32   = 32'(w_next_fill);

    always_comb begin
        w_ctl.by_value = r_by_value;
        w_ctl.mode     = (w_commit && w_ok) ? r_mode : CM_HOLD;
    end

    // Handshake outputs.
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_count, r_out_status, r_out_data};

    // Command decode at the input transfer.
    logic [IW-1:0] n_target;
    logic          n_by_value;
    logic          n_need_match;
    t_cell_mode    n_mode;
    logic          n_inc;
    logic          n_dec;
    logic [2:0]    n_status;

    always_comb begin
        n_target     = '0;
        n_by_value   = 1'b0;
        n_need_match = 1'b0;
        n_mode       = CM_HOLD;
        n_inc        = 1'b0;
        n_dec        = 1'b0;
        n_status     = ST_OK;
        case (w_func)
            FN_APPEND, FN_PREPEND: begin
                if (w_val == '0) begin
                    n_status = ST_ZERO;
                end else if (r_fill >= CW'(DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    n_mode = (w_func == FN_APPEND) ? CM_APPEND : CM_PREPEND;
                    n_inc  = 1'b1;
                end
            end
            FN_REMOVE_BACK, FN_READ_BACK: begin
                if (r_fill == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_target     = w_fill_m1[IW-1:0];
                    n_need_match = 1'b1;
                    n_dec        = (w_func == FN_REMOVE_BACK);
                end
            end
            FN_REMOVE_FRONT: begin
                if (r_fill == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_need_match = 1'b1;
                    n_mode       = CM_REMOVE;
                    n_dec        = 1'b1;
                end
            end
            FN_DELETE_AT, FN_READ_AT: begin
                if (w_pos32 >= w_fill32) begin
                    n_status = ST_RANGE;
                end else begin
                    n_target     = w_pos32[IW-1:0];
                    n_need_match = 1'b1;
                    if (w_func == FN_DELETE_AT) begin
                        n_mode = CM_REMOVE;
                        n_dec  = 1'b1;
                    end
                end
            end
            FN_DELETE_VAL: begin
                if (w_val == '0) begin
                    n_status = ST_ZERO;
                end else begin
                    n_by_value   = 1'b1;
                    n_need_match = 1'b1;
                    n_mode       = CM_REMOVE;
                    n_dec        = 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Sequencer state and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result takes the register even as the old one leaves.
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_val        <= w_val;
                        r_target     <= n_target;
                        r_by_value   <= n_by_value;
                        r_need_match <= n_need_match;
                        r_mode       <= n_mode;
                        r_inc        <= n_inc;
                        r_dec        <= n_dec;
                        r_status     <= n_status;
                        r_state      <= n_need_match ? S_MATCH : S_COMMIT;
                    end
                end
                S_MATCH: begin
                    r_state <= S_SELECT;
                end
                S_SELECT: begin
                    r_sel   <= w_first;
                    r_mask  <= w_from_first;
                    r_any   <= |w_match;
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (w_out_free) begin
                        r_fill       <= w_next_fill;
                        r_out_data   <= w_data64[31:0];
                        r_out_status <= w_ok ? r_status : ST_NOTFOUND;
                        r_out_count  <= w_count32[8:0];
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[src/alse_cell.sv]
// One list cell: holds one entry, compares it, and moves it to or from its neighbors.
`default_nettype none

module alse_cell #(
    parameter int unsigned WORD_BITS = 32,
    parameter int unsigned CW        = 9,
    parameter int unsigned IW        = 8,
    parameter int unsigned CELL_IDX  = 0
) (
    input  wire                       i_clk,
    input  wire alse_pkg::t_cell_ctl  i_ctl,
    input  wire  [IW-1:0]             i_target,
    input  wire  [CW-1:0]             i_fill,
    input  wire  [WORD_BITS-1:0]      i_value,
    input  wire  [WORD_BITS-1:0]      i_left,
    input  wire  [WORD_BITS-1:0]      i_right,
    input  wire                       i_rm,
    output logic [WORD_BITS-1:0]      o_word,
    output logic                      o_match
);
    import alse_pkg::*;

    localparam logic [CW-1:0] MY_POS = CW'(CELL_IDX);
    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;
    logic                 r_match;
    logic                 n_match;

    // Local hit: either the addressed slot or a live slot holding the value.
    always_comb begin
        if (i_ctl.by_value) begin
            n_match = (r_word == i_value) && (MY_POS < i_fill);
        end else begin
            n_match = (MY_IDX == i_target);
        end
    end

    // Next entry: hold, take the pushed word, or take a neighbor's word.
    always_comb begin
        n_word = r_word;
        case (i_ctl.mode)
            CM_APPEND: begin
                if (MY_POS == i_fill) begin
                    n_word = i_value;
                end
            end
            CM_PREPEND: begin
                n_word = i_left;
            end
            CM_REMOVE: begin
                if (i_rm) begin
                    n_word = i_right;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    // Entry storage has no reset; it is undefined until written.
    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_match <= n_match;
    end

    assign o_word  = r_word;
    assign o_match = r_match;

endmodule

`default_nettype wire

[src/alse_checker.sv]
// Port-level checks for the array list shift engine, bound to the top level.
`default_nettype none

module alse_checker #(
    parameter int unsigned DEPTH = 256
) (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_s_tvalid,
    input wire                              o_s_tready,
    input wire [alse_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input wire                              o_m_tvalid,
    input wire                              i_m_tready,
    input wire [alse_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);
    import alse_pkg::*;

    logic [31:0] w_data;
    logic [2:0]  w_status;
    logic [31:0] w_count32;
    logic        w_in_xfer;

    assign w_data    = o_m_tdata[31:0];
    assign w_status  = o_m_tdata[34:32];
    assign w_count32 = {23'd0, o_m_tdata[43:35]};
    assign w_in_xfer = i_s_tvalid && o_s_tready;

    // A failed command never releases a word.
    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_status != ST_OK) |-> (w_data == 32'd0))
        else $error("non-ok result carries data");

    // The list never reports more entries than it can hold.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_count32 <= DEPTH))
        else $error("count beyond depth");

    // An accepted append or prepend of zero is answered as ignored, never as a stored word.
    a_push_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && (i_s_tdata[2:0] == FN_APPEND || i_s_tdata[2:0] == FN_PREPEND)
         && i_s_tdata[34:3] == 32'd0 && !o_m_tvalid)
        |=> ##1 (o_m_tvalid && w_status == ST_ZERO))
        else $error("zero push not flagged");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result changed while stalled");

endmodule

bind array_list_shift_engine_unit alse_checker #(.DEPTH(DEPTH)) u_alse_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
